// File: rtl/cnns_pkg.sv
package cnns_pkg;

  localparam int unsigned DistW = 50;
  localparam int unsigned IdW   = 29;
  localparam int unsigned DispW = 25;
  localparam int unsigned PosW  = 24;
  localparam int unsigned CntW  = 7;
  // id | dx | dy | dz | dist_sq packed in one store word
  localparam int unsigned EntW  = IdW + 3 * DispW + DistW;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StTooFew  = 2'd1;
  localparam logic [1:0] StOverflow = 2'd2;

  localparam logic CfgCutSq   = 1'b0;
  localparam logic CfgNearest = 1'b1;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [DispW-1:0] dx;
    logic [DispW-1:0] dy;
    logic [DispW-1:0] dz;
    logic [DistW-1:0] dist_sq;
  } entry_t;

  typedef enum logic [4:0] {
    S_LOAD,   // accept neighbours
    S_DSQ1,   // dy^2
    S_DSQ2,   // dz^2
    S_STORE,  // compare and write
    S_DECIDE,
    S_QTOP,   // top of the outer loop
    S_RD,     // issue read of a (and b)
    S_RDW,    // read data valid, latched into a and b
    S_CMP,    // compare a,b, maybe swap
    S_SWB,    // second write of a swap
    S_UPRD,
    S_UPW,
    S_UPC,
    S_DNRD,
    S_DNW,
    S_DNC,
    S_PSW1,   // swap up,dn: write up
    S_PSW2,
    S_FINRD,
    S_FINW,
    S_FIN1,
    S_FIN2,
    S_EMRD,
    S_EMW,
    S_EMIT,
    S_TOOFEW
  } state_t;

endpackage

// File: rtl/cnns_ram.sv
module cnns_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: rtl/cutoff_nearest_neighbor_select_unit.sv
// Cutoff nearest-neighbour selector.
// s_axis: one neighbour per beat (centre, neighbour position, id); tlast marks
//   the final neighbour of a centre atom. For each neighbour beat,
//   one shared 25x25 squarer is used three times, then compare and store.
// m_axis: result beats; tlast closes the run. On the last neighbour the block
//   selects from the stored list: too few kept gives one beat with status 1;
//   nearest_count zero streams every kept neighbour in arrival order;
//   otherwise a median-of-three quickselect runs on the store, one compare or
//   one entry write per cycle through a dual-read single-write RAM, then
//   positions 0..k-1 are streamed. In the walk each scanned element is read,
//   latched and compared, and each exchange writes two entries; every pass
//   opens with the pivot choice and ends with the closing exchange. Each
//   result beat is read, latched and loaded into the output register, the
//   read waiting while the receiver stalls.
// s_axis_tready is low for the whole run; the output register holds its beat
//   while m_axis_tready is low and the sequencer waits on it.
// cfg_we/cfg_addr/cfg_wdata write cut_sq (0) and nearest_count (1); only
//   while idle. Reset clears both settings, count, overflow flag, state and
//   output valid; the store is not cleared, as only written entries are read.
module cutoff_nearest_neighbor_select_unit #(
  parameter int unsigned MAX_NEIGHBORS = 64
) (
  input  logic          clk,
  input  logic          rst,
  // fields low to high: center_x, center_y, center_z, nbr_x, nbr_y, nbr_z,
  // nbr_id, zero pad to 176 bits
  input  logic [175:0]  s_axis_tdata,
  input  logic          s_axis_tlast,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // fields low to high: out_id, out_dx, out_dy, out_dz, out_dist_sq,
  // kept_total, status, zero pad to 168 bits
  output logic [167:0]  m_axis_tdata,
  output logic          m_axis_tlast,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  input  logic          cfg_we,
  input  logic          cfg_addr,
  input  logic [49:0]   cfg_wdata
);

  localparam int unsigned AW = $clog2(MAX_NEIGHBORS);
  localparam int unsigned IW = AW + 2; // signed loop indices, room for -1 and n
  localparam int unsigned DW = cnns_pkg::DistW;
  localparam int unsigned PW = cnns_pkg::PosW;
  localparam int unsigned XW = cnns_pkg::DispW;
  localparam int unsigned CW = cnns_pkg::CntW;
  localparam logic [CW-1:0] MaxN = CW'(MAX_NEIGHBORS);

  // configuration
  logic [DW-1:0] cut_sq;
  logic [CW-1:0] nearest_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cut_sq        <= '0;
      nearest_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        cnns_pkg::CfgCutSq:   cut_sq <= cfg_wdata;
        cnns_pkg::CfgNearest: nearest_count <= cfg_wdata[CW-1:0];
        default: ;
      endcase
    end
  end

  cnns_pkg::state_t state, state_next;

  // held beat
  logic signed [XW-1:0] dx, dy, dz;
  logic [cnns_pkg::IdW-1:0] nid;
  logic                 nlast;
  logic [DW-1:0]        acc;
  logic [CW-1:0]        kept_count;
  logic                 overflow_flag;

  // selection registers
  logic signed [IW-1:0] lo, hi, up, dn, ia, ib;
  logic [2:0]           step;      // which median-of-three compare
  logic [DW-1:0]        pd;
  cnns_pkg::entry_t     ea, eb;    // latched read data
  logic [CW-1:0]        k, total, ridx;
  logic [1:0]           st;

  // shared squarer
  logic signed [XW-1:0]   sq_in;
  logic signed [2*XW-1:0] sq_prod;
  logic [DW-1:0]          sq_out;
  logic [DW-1:0]          dsq_sum;
  always_comb begin
    unique case (state)
      cnns_pkg::S_DSQ1: sq_in = dy;
      cnns_pkg::S_DSQ2: sq_in = dz;
      default:          sq_in = dx;
    endcase
  end
  assign sq_prod = sq_in * sq_in;
  assign sq_out  = DW'(unsigned'(sq_prod));
  // full squared distance in the store cycle (dx^2 comes last)
  assign dsq_sum = acc + sq_out;

  // RAM
  logic                 we;
  logic [AW-1:0]        waddr, ra, rb;
  cnns_pkg::entry_t     wdata, rda, rdb;

  cnns_ram #(.WIDTH(cnns_pkg::EntW), .DEPTH(MAX_NEIGHBORS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr_a(ra), .raddr_b(rb), .rdata_a(rda), .rdata_b(rdb)
  );

  // beat decode
  logic signed [PW-1:0] cx, cy, cz, px, py, pz;
  assign cx = s_axis_tdata[0*PW +: PW];
  assign cy = s_axis_tdata[1*PW +: PW];
  assign cz = s_axis_tdata[2*PW +: PW];
  assign px = s_axis_tdata[3*PW +: PW];
  assign py = s_axis_tdata[4*PW +: PW];
  assign pz = s_axis_tdata[5*PW +: PW];

  assign s_axis_tready = (state == cnns_pkg::S_LOAD);
  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  logic m_busy;
  assign m_busy = m_axis_tvalid && !m_axis_tready;

  // output register is loaded this cycle
  logic m_load;
  assign m_load = (state == cnns_pkg::S_EMIT) || (state == cnns_pkg::S_TOOFEW && !m_busy);

  // median-of-three compare pairs
  logic signed [IW-1:0] mid;
  assign mid = IW'(((lo + hi + IW'(2)) >>> 1) - IW'(1));

  logic signed [IW-1:0] sk;
  assign sk = signed'(IW'(k));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      cnns_pkg::S_LOAD:   if (s_acc) state_next = cnns_pkg::S_DSQ1;
      cnns_pkg::S_DSQ1:   state_next = cnns_pkg::S_DSQ2;
      cnns_pkg::S_DSQ2:   state_next = cnns_pkg::S_STORE;
      cnns_pkg::S_STORE:  state_next = nlast ? cnns_pkg::S_DECIDE : cnns_pkg::S_LOAD;
      cnns_pkg::S_DECIDE: begin
        if (kept_count == '0 || kept_count < nearest_count) state_next = cnns_pkg::S_TOOFEW;
        else if (nearest_count == '0) state_next = cnns_pkg::S_EMRD;
        else state_next = cnns_pkg::S_QTOP;
      end
      cnns_pkg::S_QTOP:   state_next = cnns_pkg::S_RD;
      cnns_pkg::S_RD:     state_next = cnns_pkg::S_RDW;
      cnns_pkg::S_RDW:    state_next = cnns_pkg::S_CMP;
      cnns_pkg::S_CMP: begin
        if (hi <= lo + IW'(1)) begin
          state_next = (hi == lo + IW'(1) && eb.dist_sq < ea.dist_sq) ? cnns_pkg::S_SWB
                                                                      : cnns_pkg::S_EMRD;
        end else if (step == 3'd0 || (step == 3'd1 && ea.dist_sq > eb.dist_sq)
                     || (step == 3'd2 && ea.dist_sq > eb.dist_sq)
                     || (step == 3'd3 && ea.dist_sq > eb.dist_sq)) begin
          state_next = cnns_pkg::S_SWB;
        end else if (step == 3'd3) begin
          state_next = cnns_pkg::S_UPRD;
        end else begin
          state_next = cnns_pkg::S_RD;
        end
      end
      cnns_pkg::S_SWB: begin
        if (hi <= lo + IW'(1)) state_next = cnns_pkg::S_EMRD;
        else if (step == 3'd3) state_next = cnns_pkg::S_UPRD;
        else state_next = cnns_pkg::S_RD;
      end
      cnns_pkg::S_UPRD:   state_next = cnns_pkg::S_UPW;
      cnns_pkg::S_UPW:    state_next = cnns_pkg::S_UPC;
      cnns_pkg::S_UPC:
        if (!(up < hi && ea.dist_sq < pd)) state_next = cnns_pkg::S_DNRD;
        else state_next = cnns_pkg::S_UPRD;
      cnns_pkg::S_DNRD:   state_next = cnns_pkg::S_DNW;
      cnns_pkg::S_DNW:    state_next = cnns_pkg::S_DNC;
      cnns_pkg::S_DNC:
        if (!(dn > lo && eb.dist_sq > pd)) begin
          state_next = (dn < up) ? cnns_pkg::S_FINRD : cnns_pkg::S_PSW1;
        end else begin
          state_next = cnns_pkg::S_DNRD;
        end
      cnns_pkg::S_PSW1:   state_next = cnns_pkg::S_PSW2;
      cnns_pkg::S_PSW2:   state_next = cnns_pkg::S_UPRD;
      cnns_pkg::S_FINRD:  state_next = cnns_pkg::S_FINW;
      cnns_pkg::S_FINW:   state_next = cnns_pkg::S_FIN1;
      cnns_pkg::S_FIN1:   state_next = cnns_pkg::S_FIN2;
      cnns_pkg::S_FIN2:   state_next = cnns_pkg::S_QTOP;
      cnns_pkg::S_EMRD:   if (!m_busy) state_next = cnns_pkg::S_EMW;
      cnns_pkg::S_EMW:    state_next = cnns_pkg::S_EMIT;
      cnns_pkg::S_EMIT:
        state_next = (ridx == total - CW'(1)) ? cnns_pkg::S_LOAD : cnns_pkg::S_EMRD;
      cnns_pkg::S_TOOFEW: if (!m_busy) state_next = cnns_pkg::S_LOAD;
      default:            state_next = cnns_pkg::S_LOAD;
    endcase
  end

  // read addresses and writes
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = ea;
    ra    = ia[AW-1:0];
    rb    = ib[AW-1:0];
    unique case (state)
      cnns_pkg::S_STORE: begin
        we    = (dsq_sum < cut_sq) && (kept_count < MaxN);
        waddr = kept_count[AW-1:0];
        wdata = '{id: nid, dx: dx, dy: dy, dz: dz, dist_sq: dsq_sum};
      end
      cnns_pkg::S_CMP: begin // first write of a swap: a gets b
        we    = 1'b1;
        waddr = ia[AW-1:0];
        wdata = eb;
        if (hi <= lo + IW'(1)) we = (hi == lo + IW'(1)) && (eb.dist_sq < ea.dist_sq);
        else if (step != 3'd0) we = ea.dist_sq > eb.dist_sq;
      end
      cnns_pkg::S_SWB: begin
        we    = 1'b1;
        waddr = ib[AW-1:0];
        wdata = ea;
      end
      cnns_pkg::S_UPRD: ra = AW'(up + IW'(1));
      cnns_pkg::S_DNRD: rb = AW'(dn - IW'(1));
      cnns_pkg::S_PSW1: begin
        we = 1'b1; waddr = up[AW-1:0]; wdata = eb;
      end
      cnns_pkg::S_PSW2: begin
        we = 1'b1; waddr = dn[AW-1:0]; wdata = ea;
      end
      cnns_pkg::S_FINRD: begin
        ra = AW'(lo + IW'(1)); rb = dn[AW-1:0];
      end
      cnns_pkg::S_FIN1: begin
        we = 1'b1; waddr = AW'(lo + IW'(1)); wdata = eb;
      end
      cnns_pkg::S_FIN2: begin
        we = 1'b1; waddr = dn[AW-1:0]; wdata = ea;
      end
      cnns_pkg::S_EMRD: ra = ridx[AW-1:0];
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= cnns_pkg::S_LOAD;
      kept_count    <= '0;
      overflow_flag <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (m_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        cnns_pkg::S_LOAD: if (s_acc) begin
          dx    <= XW'(px) - XW'(cx);
          dy    <= XW'(py) - XW'(cy);
          dz    <= XW'(pz) - XW'(cz);
          nid   <= s_axis_tdata[6*PW +: cnns_pkg::IdW];
          nlast <= s_axis_tlast;
        end
        cnns_pkg::S_DSQ1: acc <= sq_out;
        cnns_pkg::S_DSQ2: acc <= acc + sq_out;
        cnns_pkg::S_STORE: begin
          acc <= dsq_sum;
          if (dsq_sum < cut_sq) begin
            if (kept_count < MaxN) kept_count <= kept_count + CW'(1);
            else overflow_flag <= 1'b1;
          end
        end
        cnns_pkg::S_DECIDE: begin
          k    <= nearest_count;
          ridx <= '0;
          st   <= overflow_flag ? cnns_pkg::StOverflow : cnns_pkg::StOk;
          total <= (nearest_count == '0) ? kept_count : nearest_count;
          lo   <= '0;
          hi   <= signed'(IW'(kept_count)) - IW'(1);
        end
        cnns_pkg::S_QTOP: begin
          step <= 3'd0;
          if (hi <= lo + IW'(1)) begin
            ia <= lo; ib <= hi;
          end else begin
            ia <= mid; ib <= lo + IW'(1);
          end
        end
        cnns_pkg::S_RDW: begin
          ea <= rda; eb <= rdb;
        end
        cnns_pkg::S_SWB, cnns_pkg::S_CMP: begin
          // advance to the next compare pair once the pair is settled
          if ((state == cnns_pkg::S_SWB) || (state_next == cnns_pkg::S_RD)
              || (state_next == cnns_pkg::S_UPRD)) begin
            step <= step + 3'd1;
            unique case (step)
              3'd0: begin ia <= lo; ib <= hi; end
              3'd1: begin ia <= lo + IW'(1); ib <= hi; end
              3'd2: begin ia <= lo; ib <= lo + IW'(1); end
              default: begin
                // pivot is the final value at lo+1
                pd <= (state == cnns_pkg::S_SWB) ? ea.dist_sq : eb.dist_sq;
                up <= lo + IW'(1);
                dn <= hi;
              end
            endcase
          end
        end
        cnns_pkg::S_UPRD: up <= up + IW'(1);
        cnns_pkg::S_UPW:  ea <= rda;
        cnns_pkg::S_DNRD: dn <= dn - IW'(1);
        cnns_pkg::S_DNW:  eb <= rdb;
        cnns_pkg::S_FINW: begin
          ea <= rda; eb <= rdb;
        end
        cnns_pkg::S_FIN2: begin
          if (dn + IW'(1) >= sk) hi <= dn - IW'(1);
          if (dn + IW'(1) <= sk) lo <= up;
        end
        cnns_pkg::S_EMW: ea <= rda;
        cnns_pkg::S_EMIT: begin
          m_axis_tdata  <= {5'b0, st, total, ea.dist_sq, ea.dz, ea.dy, ea.dx, ea.id};
          m_axis_tlast  <= (ridx == total - CW'(1));
          ridx          <= ridx + CW'(1);
          if (ridx == total - CW'(1)) begin
            kept_count    <= '0;
            overflow_flag <= 1'b0;
          end
        end
        cnns_pkg::S_TOOFEW: if (!m_busy) begin
          m_axis_tdata  <= {5'b0, cnns_pkg::StTooFew, kept_count, 154'b0};
          m_axis_tlast  <= 1'b1;
          kept_count    <= '0;
          overflow_flag <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // a new neighbour is never taken while a run is still being produced
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> (state == cnns_pkg::S_LOAD))
    else $error("input ready outside load");

  assert property (@(posedge clk) disable iff (rst)
    kept_count <= MaxN)
    else $error("kept count above capacity");

  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

// File: tb/tb.sv
module tb;

  localparam int Depth   = 64;
  localparam int WdLimit = 50000;
  localparam int HoldLen = 2500;

  localparam int PosW  = cnns_pkg::PosW;
  localparam int IdW   = cnns_pkg::IdW;
  localparam int DispW = cnns_pkg::DispW;
  localparam int DistW = cnns_pkg::DistW;
  localparam int CntW  = cnns_pkg::CntW;

  // one neighbour beat as the block sees it
  typedef struct {
    logic signed [PosW-1:0] cx, cy, cz, nx, ny, nz;
    logic [IdW-1:0] id;
    logic last;
  } nbr_t;

  // one result beat
  typedef struct {
    logic [IdW-1:0] id;
    logic [DispW-1:0] dx, dy, dz;
    logic [DistW-1:0] dist_sq;
    logic [CntW-1:0] total;
    logic [1:0] status;
    logic last;
  } sel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [175:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0, s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [167:0] m_axis_tdata;
  logic m_axis_tlast, m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_addr = cnns_pkg::CfgCutSq;
  logic [49:0] cfg_wdata = '0;

  cutoff_nearest_neighbor_select_unit #(.MAX_NEIGHBORS(Depth)) dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state: shadow registers and the kept list
  logic [DistW-1:0] cut_q;
  logic [CntW-1:0]  k_q;
  logic [DistW-1:0] kd [Depth];
  logic [IdW-1:0]   kid[Depth];
  logic signed [DispW-1:0] kx[Depth], ky[Depth], kz[Depth];
  int  n_kept;
  bit  dropped;
  sel_t pending_sel[$];   // results still owed by the block
  int  errors;
  int  idle_cycles;
  bit  rx_hold = 1'b0;    // asks the receiver for one long stall
  logic [1:0] seen_status; // status of the latest result beat

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void swap_kept(int a, int b);
    logic [DistW-1:0] td; logic [IdW-1:0] ti; logic signed [DispW-1:0] tx, ty, tz;
    td = kd[a]; kd[a] = kd[b]; kd[b] = td;
    ti = kid[a]; kid[a] = kid[b]; kid[b] = ti;
    tx = kx[a]; kx[a] = kx[b]; kx[b] = tx;
    ty = ky[a]; ky[a] = ky[b]; ky[b] = ty;
    tz = kz[a]; kz[a] = kz[b]; kz[b] = tz;
  endfunction

  // median-of-three quickselect, k smallest into 0..k-1
  function automatic void partial_order(int k, int n);
    int lo, hi, mid, up, dn;
    logic [DistW-1:0] pd;
    lo = 0; hi = n - 1;
    forever begin
      if (hi <= lo + 1) begin
        if (hi == lo + 1 && kd[hi] < kd[lo]) swap_kept(lo, hi);
        return;
      end
      mid = ((lo + hi + 2) >> 1) - 1;
      swap_kept(mid, lo + 1);
      if (kd[lo] > kd[hi]) swap_kept(lo, hi);
      if (kd[lo + 1] > kd[hi]) swap_kept(lo + 1, hi);
      if (kd[lo] > kd[lo + 1]) swap_kept(lo, lo + 1);
      up = lo + 1; dn = hi; pd = kd[lo + 1];
      forever begin
        do up++; while (up < hi && kd[up] < pd);
        do dn--; while (dn > lo && kd[dn] > pd);
        if (dn < up) break;
        swap_kept(up, dn);
      end
      swap_kept(lo + 1, dn);
      if (dn + 1 >= k) hi = dn - 1;
      if (dn + 1 <= k) lo = up;
    end
  endfunction

  // fold one accepted neighbour into the predictor, queue results on last
  function automatic void predict_select(nbr_t b);
    logic signed [DispW-1:0] dx, dy, dz;
    logic [DistW-1:0] dsq;
    sel_t r;
    int cnt;
    dx = DispW'(b.nx) - DispW'(b.cx);
    dy = DispW'(b.ny) - DispW'(b.cy);
    dz = DispW'(b.nz) - DispW'(b.cz);
    dsq = DistW'(64'(dx) * 64'(dx) + 64'(dy) * 64'(dy) + 64'(dz) * 64'(dz));
    if (dsq < cut_q) begin
      if (n_kept < Depth) begin
        kd[n_kept] = dsq; kid[n_kept] = b.id;
        kx[n_kept] = dx; ky[n_kept] = dy; kz[n_kept] = dz;
        n_kept++;
      end else dropped = 1'b1;
    end
    if (!b.last) return;
    if (n_kept == 0 || n_kept < int'(k_q)) begin
      r = '{default: '0};
      r.total = CntW'(n_kept); r.status = cnns_pkg::StTooFew; r.last = 1'b1;
      pending_sel.push_back(r);
    end else begin
      if (k_q != 0) begin
        partial_order(int'(k_q), n_kept);
        cnt = int'(k_q);
      end else cnt = n_kept;
      for (int i = 0; i < cnt; i++) begin
        r.id = kid[i]; r.dx = kx[i]; r.dy = ky[i]; r.dz = kz[i]; r.dist_sq = kd[i];
        r.total = CntW'(cnt); r.status = dropped ? cnns_pkg::StOverflow : cnns_pkg::StOk;
        r.last = (i == cnt - 1);
        pending_sel.push_back(r);
      end
    end
    n_kept = 0; dropped = 1'b0;
  endfunction

  // check each result beat against the oldest expectation
  always @(posedge clk) begin
    sel_t g, w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      {g.status, g.total, g.dist_sq, g.dz, g.dy, g.dx, g.id} = m_axis_tdata[162:0];
      g.last = m_axis_tlast;
      seen_status = g.status;
      if (pending_sel.size() == 0) begin
        report("unexpected beat", 64'(g.id), 64'd0);
      end else begin
        w = pending_sel.pop_front();
        if (g.id != w.id) report("id", g.id, w.id);
        if (g.dx != w.dx) report("dx", g.dx, w.dx);
        if (g.dy != w.dy) report("dy", g.dy, w.dy);
        if (g.dz != w.dz) report("dz", g.dz, w.dz);
        if (g.dist_sq != w.dist_sq) report("dist_sq", g.dist_sq, w.dist_sq);
        if (g.total != w.total) report("kept_total", g.total, w.total);
        if (g.status != w.status) report("status", g.status, w.status);
        if (g.last != w.last) report("tlast", g.last, w.last);
      end
    end
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WdLimit) begin
      $display("** cutoff_nearest_neighbor_select_unit: FAILED **");
      $finish;
    end
  end

  // receiver: own stall pattern, stretches of full rate, and a long hold-off
  initial begin
    int mode;
    @(negedge clk);
    forever begin
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
        repeat (HoldLen) @(negedge clk);
        rx_hold = 1'b0;
      end
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(5, 40)) begin
        @(negedge clk);
        if (mode == 0) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 3) != 0) || mode == 3 && $urandom_range(0, 1);
      end
    end
  end

  task automatic write_reg(logic addr, logic [49:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_addr <= addr; cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (addr == cnns_pkg::CfgCutSq) cut_q = val; else k_q = val[CntW-1:0];
  endtask

  // offer one neighbour, wait for acceptance
  task automatic send_nbr(nbr_t b);
    s_axis_tdata <= {3'b0, b.id, b.nz, b.ny, b.nx, b.cz, b.cy, b.cx};
    s_axis_tlast <= b.last;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_select(b);
    @(negedge clk);
  endtask

  task automatic drop_valid();
    s_axis_tvalid <= 1'b0;
  endtask

  // wait out all owed results, then the quiet cycles after a set
  task automatic drain();
    drop_valid();
    while (pending_sel.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic nbr_t rand_nbr(int spread, bit last);
    nbr_t b;
    b.cx = PosW'($urandom); b.cy = PosW'($urandom); b.cz = PosW'($urandom);
    if (spread == 0) begin
      b.nx = PosW'($urandom); b.ny = PosW'($urandom); b.nz = PosW'($urandom);
    end else begin
      b.nx = PosW'(b.cx + $signed($urandom_range(0, 2 * spread)) - spread);
      b.ny = PosW'(b.cy + $signed($urandom_range(0, 2 * spread)) - spread);
      b.nz = PosW'(b.cz + $signed($urandom_range(0, 2 * spread)) - spread);
    end
    b.id = IdW'($urandom);
    b.last = last;
    return b;
  endfunction

  // directed rows; expected beats typed where obvious, else predictor
  typedef struct {
    logic signed [PosW-1:0] c, n;
    logic [IdW-1:0] id;
    logic last;
    bit typed;
    logic [1:0] st;
  } row_t;

  row_t rows[$];

  initial begin
    nbr_t b;
    int set_len, spread;
    errors = 0; n_kept = 0; dropped = 0;
    cut_q = '0; k_q = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // after reset cut_sq is zero: nothing is kept, too-few beat
    rows = '{
      '{24'sh000000, 24'sh000000, 29'h0, 1'b1, 1'b1, cnns_pkg::StTooFew}
    };
    foreach (rows[i]) begin
      b = '{rows[i].c, rows[i].c, rows[i].c, rows[i].n, rows[i].n, rows[i].n,
            rows[i].id, rows[i].last};
      send_nbr(b);
      if (rows[i].typed) begin
        drain();
        if (seen_status != rows[i].st) report("typed status", seen_status, rows[i].st);
      end
    end
    drain();

    // widest cutoff, keep all: extremes of position and id
    write_reg(cnns_pkg::CfgCutSq, 50'h3FFFFFFFFFFFF);
    write_reg(cnns_pkg::CfgNearest, 50'd0);
    rows = '{
      '{24'sh800000, 24'sd8388607, 29'h1FFFFFFF, 1'b0, 1'b0, cnns_pkg::StOk},
      '{24'sd8388607, 24'sh800000, 29'h0, 1'b0, 1'b0, cnns_pkg::StOk},
      '{24'sd0, 24'sd0, 29'h15555555, 1'b0, 1'b0, cnns_pkg::StOk},
      '{-24'sd1, 24'sd1, 29'h0AAAAAAA, 1'b1, 1'b0, cnns_pkg::StOk}
    };
    foreach (rows[i]) begin
      b = '{rows[i].c, rows[i].c, rows[i].c, rows[i].n, rows[i].n, rows[i].n,
            rows[i].id, rows[i].last};
      send_nbr(b);
    end
    drain();

    // quickselect k=3 on seven, then k above the kept count, k above depth
    write_reg(cnns_pkg::CfgNearest, 50'd3);
    for (int i = 0; i < 7; i++) send_nbr(rand_nbr(5000, i == 6));
    drain();
    write_reg(cnns_pkg::CfgNearest, 50'd64);
    for (int i = 0; i < 3; i++) send_nbr(rand_nbr(5000, i == 2));
    drain();
    write_reg(cnns_pkg::CfgNearest, 50'd127);
    send_nbr(rand_nbr(10, 1'b1));
    drain();
    // k=1 on a single neighbour
    write_reg(cnns_pkg::CfgNearest, 50'd1);
    send_nbr(rand_nbr(10, 1'b1));
    drain();

    // overflow: 66 kept candidates, k=2; the receiver holds off while the
    // next set is already offered, so the input stalls behind the results
    write_reg(cnns_pkg::CfgNearest, 50'd2);
    rx_hold = 1'b1;
    for (int i = 0; i < 66; i++) send_nbr(rand_nbr(3000, i == 65));
    for (int i = 0; i < 3; i++) send_nbr(rand_nbr(3000, i == 2));
    drain();

    // random sets, settings changed between phases
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: write_reg(cnns_pkg::CfgCutSq, 50'($urandom_range(1, 1 << 30)) << 10);
        1: write_reg(cnns_pkg::CfgCutSq, 50'({$urandom, $urandom}));
        default: write_reg(cnns_pkg::CfgCutSq, 50'h3FFFFFFFFFFFF);
      endcase
      write_reg(cnns_pkg::CfgNearest, (ph == 5) ? 50'd0 : 50'($urandom_range(0, 8)));
      for (int s = 0; s < 4; s++) begin
        set_len = $urandom_range(1, 10);
        spread = ($urandom_range(0, 4) == 0) ? 0 : 1 << $urandom_range(4, 20);
        for (int i = 0; i < set_len; i++) begin
          send_nbr(rand_nbr(spread, i == set_len - 1));
          if ($urandom_range(0, 3) == 0) begin
            drop_valid();
            repeat ($urandom_range(1, 12)) @(negedge clk);
          end
        end
      end
      drain();
    end

    if (errors == 0) $display("** cutoff_nearest_neighbor_select_unit: PASSED **");
    else $display("** cutoff_nearest_neighbor_select_unit: FAILED **");
    $finish;
  end

endmodule
